// ===== rtl/core/i2cbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cbe_pkg;

  // Command codes carried in the op field.
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_WRITE     = 3'd3;
  localparam logic [2:0] OP_READ_ACK  = 3'd4;
  localparam logic [2:0] OP_READ_NACK = 3'd5;

  // Configuration register indexes.
  localparam logic REG_DELAY_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] DELAY_TICKS_RST = 16'd2;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd5000;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] rx_byte;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2cbe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface i2cbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output op, output tx_byte, output sda_in, input ready);
  modport sink   (input valid, input op, input tx_byte, input sda_in, output ready);
endinterface

interface i2cbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic       ack_error;
  logic [7:0] rx_byte;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output ack_error, output rx_byte, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input ack_error, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/i2cbe_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cbe_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [2:0]       op_i,
  input  wire logic [7:0]       tx_byte_i,
  input  wire logic             sda_in_i,
  input  wire logic [15:0]      delay_ticks_i,
  input  wire logic [15:0]      ack_timeout_i,
  output i2cbe_pkg::res_t       res_o
);

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_ST_B   = 5'd1;
  localparam logic [4:0] PH_ST_C   = 5'd2;
  localparam logic [4:0] PH_SP_B   = 5'd3;
  localparam logic [4:0] PH_SP_C   = 5'd4;
  localparam logic [4:0] PH_WR_HI  = 5'd5;
  localparam logic [4:0] PH_WR_LO  = 5'd6;
  localparam logic [4:0] PH_AK_HI  = 5'd7;
  localparam logic [4:0] PH_AK_SMP = 5'd8;
  localparam logic [4:0] PH_AF_B   = 5'd9;
  localparam logic [4:0] PH_AF_C   = 5'd10;
  localparam logic [4:0] PH_RD_HI  = 5'd11;
  localparam logic [4:0] PH_RD_LO  = 5'd12;
  localparam logic [4:0] PH_RA_HI  = 5'd13;
  localparam logic [4:0] PH_RA_LO  = 5'd14;

  logic [4:0]  phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [15:0] dly_cnt_q, dly_cnt_d;
  logic [15:0] tmo_cnt_q, tmo_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  rx_q, rx_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        nack_q, nack_d;
  logic        done, err;

  logic [15:0] dly_load;
  logic [15:0] limit;
  logic        ack_last;
  logic [7:0]  rd_shift;
  logic [3:0]  bit_cnt_inc;

  // A zero register value behaves as one.
  assign dly_load    = (delay_ticks_i == 16'd0) ? 16'd1 : delay_ticks_i;
  assign limit       = (ack_timeout_i == 16'd0) ? 16'd1 : ack_timeout_i;
  assign ack_last    = ({1'b0, tmo_cnt_q} + 17'd1) >= {1'b0, limit};
  assign rd_shift    = {shift_q[6:0], sda_in_i};
  assign bit_cnt_inc = bit_cnt_q + 4'd1;

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    dly_cnt_d = dly_cnt_q;
    tmo_cnt_d = tmo_cnt_q;
    shift_d   = shift_q;
    rx_d      = rx_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    nack_d    = nack_q;
    done      = 1'b0;
    err       = 1'b0;

    if (phase_q == PH_IDLE) begin
      unique case (op_i) inside
        i2cbe_pkg::OP_START: begin
          sda_d = 1'b1; scl_d = 1'b1; dly_cnt_d = dly_load; phase_d = PH_ST_B;
        end
        i2cbe_pkg::OP_STOP: begin
          sda_d = 1'b0; scl_d = 1'b0; dly_cnt_d = dly_load; phase_d = PH_SP_B;
        end
        i2cbe_pkg::OP_WRITE: begin
          // The MSB goes out together with the first SCL low.
          scl_d     = 1'b0;
          sda_d     = tx_byte_i[7];
          shift_d   = {tx_byte_i[6:0], 1'b0};
          bit_cnt_d = 4'd1;
          dly_cnt_d = dly_load;
          phase_d   = PH_WR_HI;
        end
        i2cbe_pkg::OP_READ_ACK, i2cbe_pkg::OP_READ_NACK: begin
          nack_d    = (op_i == i2cbe_pkg::OP_READ_NACK);
          sda_d     = 1'b1;
          scl_d     = 1'b0;
          bit_cnt_d = 4'd0;
          shift_d   = 8'd0;
          dly_cnt_d = dly_load;
          phase_d   = PH_RD_HI;
        end
        default: begin
        end
      endcase
    end else if (dly_cnt_q > 16'd1) begin
      dly_cnt_d = dly_cnt_q - 16'd1;
    end else begin
      unique case (phase_q)
        PH_ST_B: begin
          sda_d = 1'b0; dly_cnt_d = dly_load; phase_d = PH_ST_C;
        end
        PH_ST_C: begin
          scl_d = 1'b0; done = 1'b1; phase_d = PH_IDLE;
        end
        PH_SP_B, PH_AF_B: begin
          scl_d = 1'b1; sda_d = 1'b1; dly_cnt_d = dly_load;
          phase_d = (phase_q == PH_SP_B) ? PH_SP_C : PH_AF_C;
        end
        PH_SP_C: begin
          done = 1'b1; phase_d = PH_IDLE;
        end
        PH_WR_HI: begin
          scl_d = 1'b1; dly_cnt_d = dly_load; phase_d = PH_WR_LO;
        end
        PH_WR_LO: begin
          scl_d     = 1'b0;
          dly_cnt_d = dly_load;
          if (bit_cnt_q < i2cbe_pkg::BITS_PER_BYTE) begin
            sda_d     = shift_q[7];
            shift_d   = {shift_q[6:0], 1'b0};
            bit_cnt_d = bit_cnt_inc;
            phase_d   = PH_WR_HI;
          end else begin
            sda_d   = 1'b1;
            phase_d = PH_AK_HI;
          end
        end
        PH_AK_HI: begin
          scl_d = 1'b1; tmo_cnt_d = 16'd0; dly_cnt_d = dly_load; phase_d = PH_AK_SMP;
        end
        PH_AK_SMP: begin
          if (!sda_in_i) begin
            scl_d = 1'b0; done = 1'b1; phase_d = PH_IDLE;
          end else if (ack_last) begin
            // No acknowledge in time: release the bus with a stop.
            sda_d = 1'b0; scl_d = 1'b0; dly_cnt_d = dly_load; phase_d = PH_AF_B;
          end else begin
            tmo_cnt_d = tmo_cnt_q + 16'd1;
            dly_cnt_d = dly_load;
          end
        end
        PH_AF_C: begin
          done = 1'b1; err = 1'b1; phase_d = PH_IDLE;
        end
        PH_RD_HI: begin
          scl_d     = 1'b1;
          shift_d   = rd_shift;
          bit_cnt_d = bit_cnt_inc;
          if (bit_cnt_inc >= i2cbe_pkg::BITS_PER_BYTE) begin
            rx_d = rd_shift;
          end
          dly_cnt_d = dly_load;
          phase_d   = PH_RD_LO;
        end
        PH_RD_LO: begin
          scl_d     = 1'b0;
          dly_cnt_d = dly_load;
          if (bit_cnt_q < i2cbe_pkg::BITS_PER_BYTE) begin
            phase_d = PH_RD_HI;
          end else begin
            sda_d   = nack_q;
            phase_d = PH_RA_HI;
          end
        end
        PH_RA_HI: begin
          scl_d = 1'b1; dly_cnt_d = dly_load; phase_d = PH_RA_LO;
        end
        PH_RA_LO: begin
          scl_d = 1'b0; done = 1'b1; phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= 4'd0;
      dly_cnt_q <= 16'd0;
      tmo_cnt_q <= 16'd0;
      shift_q   <= 8'd0;
      rx_q      <= 8'd0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      nack_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      dly_cnt_q <= dly_cnt_d;
      tmo_cnt_q <= tmo_cnt_d;
      shift_q   <= shift_d;
      rx_q      <= rx_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      nack_q    <= nack_d;
    end
  end

  always_comb begin
    res_o.scl_out   = scl_d;
    res_o.sda_out   = sda_d;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.ack_error = err;
    res_o.rx_byte   = rx_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/i2cbe_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Result register with one skid entry behind it.
module i2cbe_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire i2cbe_pkg::res_t  res_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_ready_i,
  output i2cbe_pkg::res_t       res_o
);

  i2cbe_pkg::res_t out_q, out_d;
  i2cbe_pkg::res_t skid_q, skid_d;
  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_valid_q && pop_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = res_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (out_valid_q) begin
      if (push_i) begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (push_i) begin
      out_d       = res_i;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/i2c_master_bit_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// in_i      in   valid/ready        op, tx_byte, sda_in (one bus tick)
// out_o     out  valid/ready        scl_out, sda_out, busy_res, done_res,
//                                   ack_error, rx_byte
// cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (write only)
//
// Every accepted tick yields exactly one result, held in the result register or the skid
// entry; a tick can be taken every cycle, limited only by the one-entry skid behind the result register.
// Reset (rst_ni, asynchronous, active low) leaves the bus released, the
// sequencer idle and the registers at delay 2 and timeout 5000.
// When out_o stalls, one more tick is taken into the skid entry, then in_i.ready drops.
module i2c_master_bit_engine_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  i2cbe_in_if.sink   in_i,
  i2cbe_out_if.source out_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0]     delay_ticks_q;
  logic [15:0]     ack_timeout_q;
  logic            accept;
  logic            buf_ready;
  i2cbe_pkg::res_t seq_res;
  i2cbe_pkg::res_t out_res;

  assign accept     = in_i.valid && buf_ready;
  assign in_i.ready = buf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ticks_q <= i2cbe_pkg::DELAY_TICKS_RST;
      ack_timeout_q <= i2cbe_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2cbe_pkg::REG_DELAY_TICKS: delay_ticks_q <= cfg_data_i;
        i2cbe_pkg::REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  i2cbe_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (in_i.op),
    .tx_byte_i     (in_i.tx_byte),
    .sda_in_i      (in_i.sda_in),
    .delay_ticks_i (delay_ticks_q),
    .ack_timeout_i (ack_timeout_q),
    .res_o         (seq_res)
  );

  i2cbe_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (seq_res),
    .ready_o     (buf_ready),
    .valid_o     (out_o.valid),
    .pop_ready_i (out_o.ready),
    .res_o       (out_res)
  );

  assign out_o.scl_out   = out_res.scl_out;
  assign out_o.sda_out   = out_res.sda_out;
  assign out_o.busy_res  = out_res.busy_res;
  assign out_o.done_res  = out_res.done_res;
  assign out_o.ack_error = out_res.ack_error;
  assign out_o.rx_byte   = out_res.rx_byte;

  // An accepted tick always shows up as a pending result on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_o.valid)
    else $error("accepted tick left no pending result");

  // Input is only held off while a result is waiting on the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no pending result");

  // A result with an acknowledge error always finishes a command.
  a_error_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && seq_res.ack_error |-> seq_res.done_res && !seq_res.busy_res)
    else $error("acknowledge error without command completion");

endmodule

`default_nettype wire

// ===== sim/i2cbe_checker.sv =====
`timescale 1ns / 1ps

module i2cbe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cbe_in_if         in_i,
  i2cbe_out_if        out_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  // The action named by each step is the one taken when its delay runs out.
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START_SDA_LOW,
    SEQ_START_END,
    SEQ_STOP_RELEASE,
    SEQ_STOP_END,
    SEQ_WBIT_RISE,
    SEQ_WBIT_FALL,
    SEQ_ACK_RISE,
    SEQ_ACK_POLL,
    SEQ_ABORT_RELEASE,
    SEQ_ABORT_END,
    SEQ_RBIT_RISE,
    SEQ_RBIT_FALL,
    SEQ_MACK_RISE,
    SEQ_MACK_FALL
  } seq_e;

  logic [15:0] delay_ticks_q;
  logic [15:0] ack_timeout_q;

  seq_e        seq_q;
  logic [3:0]  bit_cnt_q;
  logic [15:0] dly_cnt_q;
  logic [15:0] poll_cnt_q;
  logic [7:0]  shreg_q;
  logic [7:0]  rx_q;
  logic        scl_q;
  logic        sda_q;
  logic        nack_q;

  i2cbe_pkg::res_t tick_results_q[$];
  i2cbe_pkg::res_t predicted;
  i2cbe_pkg::res_t want;
  int   fails_q = 0;
  int   pending_q = 0;
  int   result_idx = 0;

  assign fail_count_o = fails_q;
  assign pending_o    = pending_q;

  task automatic flag_error(input string msg);
    fails_q++;
    $display("%0t checker: result %0d: %s", $time, result_idx, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
    if (got !== exp_v) flag_error($sformatf("%s is %0h, expected %0h", name, got, exp_v));
  endtask

  // A programmed delay of zero behaves as one tick.
  task automatic reload_delay();
    dly_cnt_q = (delay_ticks_q == 16'd0) ? 16'd1 : delay_ticks_q;
  endtask

  task automatic shift_out_bit();
    sda_q     = shreg_q[7];
    shreg_q   = {shreg_q[6:0], 1'b0};
    bit_cnt_q = bit_cnt_q + 4'd1;
  endtask

  task automatic advance_bus_tick(input logic [2:0] op, input logic [7:0] tx,
                                  input logic sda_in, output i2cbe_pkg::res_t r);
    logic        fin;
    logic        abort;
    logic [16:0] limit;
    fin   = 1'b0;
    abort = 1'b0;
    limit = (ack_timeout_q == 16'd0) ? 17'd1 : {1'b0, ack_timeout_q};
    if (seq_q == SEQ_IDLE) begin
      case (op)
        i2cbe_pkg::OP_START: begin
          sda_q = 1'b1;
          scl_q = 1'b1;
          reload_delay();
          seq_q = SEQ_START_SDA_LOW;
        end
        i2cbe_pkg::OP_STOP: begin
          sda_q = 1'b0;
          scl_q = 1'b0;
          reload_delay();
          seq_q = SEQ_STOP_RELEASE;
        end
        i2cbe_pkg::OP_WRITE: begin
          shreg_q   = tx;
          bit_cnt_q = 4'd0;
          scl_q     = 1'b0;
          shift_out_bit();
          reload_delay();
          seq_q = SEQ_WBIT_RISE;
        end
        i2cbe_pkg::OP_READ_ACK, i2cbe_pkg::OP_READ_NACK: begin
          nack_q    = (op == i2cbe_pkg::OP_READ_NACK);
          sda_q     = 1'b1;
          scl_q     = 1'b0;
          bit_cnt_q = 4'd0;
          shreg_q   = 8'd0;
          reload_delay();
          seq_q = SEQ_RBIT_RISE;
        end
        default: ;
      endcase
    end else if (dly_cnt_q > 16'd1) begin
      dly_cnt_q = dly_cnt_q - 16'd1;
    end else begin
      case (seq_q)
        SEQ_START_SDA_LOW: begin
          sda_q = 1'b0;
          reload_delay();
          seq_q = SEQ_START_END;
        end
        SEQ_START_END: begin
          scl_q = 1'b0;
          fin   = 1'b1;
          seq_q = SEQ_IDLE;
        end
        SEQ_STOP_RELEASE: begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          reload_delay();
          seq_q = SEQ_STOP_END;
        end
        SEQ_STOP_END: begin
          fin   = 1'b1;
          seq_q = SEQ_IDLE;
        end
        SEQ_WBIT_RISE: begin
          scl_q = 1'b1;
          reload_delay();
          seq_q = SEQ_WBIT_FALL;
        end
        SEQ_WBIT_FALL: begin
          scl_q = 1'b0;
          if (bit_cnt_q < i2cbe_pkg::BITS_PER_BYTE) begin
            shift_out_bit();
            reload_delay();
            seq_q = SEQ_WBIT_RISE;
          end else begin
            sda_q = 1'b1;
            reload_delay();
            seq_q = SEQ_ACK_RISE;
          end
        end
        SEQ_ACK_RISE: begin
          scl_q      = 1'b1;
          poll_cnt_q = 16'd0;
          reload_delay();
          seq_q = SEQ_ACK_POLL;
        end
        SEQ_ACK_POLL: begin
          if (!sda_in) begin
            scl_q = 1'b0;
            fin   = 1'b1;
            seq_q = SEQ_IDLE;
          end else if ({1'b0, poll_cnt_q} + 17'd1 >= limit) begin
            // No acknowledge in time: release the bus with a stop.
            sda_q = 1'b0;
            scl_q = 1'b0;
            reload_delay();
            seq_q = SEQ_ABORT_RELEASE;
          end else begin
            poll_cnt_q = poll_cnt_q + 16'd1;
            reload_delay();
          end
        end
        SEQ_ABORT_RELEASE: begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          reload_delay();
          seq_q = SEQ_ABORT_END;
        end
        SEQ_ABORT_END: begin
          fin   = 1'b1;
          abort = 1'b1;
          seq_q = SEQ_IDLE;
        end
        SEQ_RBIT_RISE: begin
          scl_q     = 1'b1;
          shreg_q   = {shreg_q[6:0], sda_in};
          bit_cnt_q = bit_cnt_q + 4'd1;
          if (bit_cnt_q >= i2cbe_pkg::BITS_PER_BYTE) rx_q = shreg_q;
          reload_delay();
          seq_q = SEQ_RBIT_FALL;
        end
        SEQ_RBIT_FALL: begin
          scl_q = 1'b0;
          if (bit_cnt_q < i2cbe_pkg::BITS_PER_BYTE) begin
            reload_delay();
            seq_q = SEQ_RBIT_RISE;
          end else begin
            sda_q = nack_q;
            reload_delay();
            seq_q = SEQ_MACK_RISE;
          end
        end
        SEQ_MACK_RISE: begin
          scl_q = 1'b1;
          reload_delay();
          seq_q = SEQ_MACK_FALL;
        end
        SEQ_MACK_FALL: begin
          scl_q = 1'b0;
          fin   = 1'b1;
          seq_q = SEQ_IDLE;
        end
        default: seq_q = SEQ_IDLE;
      endcase
    end
    r.scl_out   = scl_q;
    r.sda_out   = sda_q;
    r.busy_res  = (seq_q != SEQ_IDLE);
    r.done_res  = fin;
    r.ack_error = abort;
    r.rx_byte   = rx_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ticks_q = i2cbe_pkg::DELAY_TICKS_RST;
      ack_timeout_q = i2cbe_pkg::ACK_TIMEOUT_RST;
      seq_q         = SEQ_IDLE;
      bit_cnt_q     = 4'd0;
      dly_cnt_q     = 16'd0;
      poll_cnt_q    = 16'd0;
      shreg_q       = 8'd0;
      rx_q          = 8'd0;
      scl_q         = 1'b1;
      sda_q         = 1'b1;
      nack_q        = 1'b0;
      tick_results_q.delete();
    end else begin
      // A tick taken at the same edge as a register write still sees the old value.
      if (in_i.valid && in_i.ready) begin
        advance_bus_tick(in_i.op, in_i.tx_byte, in_i.sda_in, predicted);
        tick_results_q.push_back(predicted);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          i2cbe_pkg::REG_DELAY_TICKS: delay_ticks_q = cfg_data_i;
          i2cbe_pkg::REG_ACK_TIMEOUT: ack_timeout_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_i.valid && out_i.ready) begin
        result_idx++;
        if (tick_results_q.size() == 0) begin
          flag_error("result transfer with no tick waiting for it");
        end else begin
          want = tick_results_q.pop_front();
          check_field("scl_out", {7'd0, out_i.scl_out}, {7'd0, want.scl_out});
          check_field("sda_out", {7'd0, out_i.sda_out}, {7'd0, want.sda_out});
          check_field("busy_res", {7'd0, out_i.busy_res}, {7'd0, want.busy_res});
          check_field("done_res", {7'd0, out_i.done_res}, {7'd0, want.done_res});
          check_field("ack_error", {7'd0, out_i.ack_error}, {7'd0, want.ack_error});
          check_field("rx_byte", out_i.rx_byte, want.rx_byte);
        end
      end
    end
    pending_q = tick_results_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 17;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEM_TARGET    = 550;
  localparam int FILL_CAP       = 200000;

  // Op codes that the engine defines no command for.
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;

  int ticks_sent   = 0;
  int results_seen = 0;
  int dones_seen   = 0;
  int aborts_seen  = 0;
  int cmds_issued  = 0;
  int idle_cycles  = 0;
  int hold_req     = 0;
  bit gaps_on      = 1'b1;

  i2cbe_in_if  tick_ch ();
  i2cbe_out_if res_ch ();

  i2c_master_bit_engine_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  i2cbe_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (tick_ch),
    .out_i        (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (tick_ch.valid && tick_ch.ready) ticks_sent++;
    if (res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (res_ch.done_res) dones_seen++;
      if (res_ch.ack_error) aborts_seen++;
    end
    if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb_top: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic int draw_gap();
    if (!gaps_on || $urandom_range(0, 9) < 6) return 0;
    return $urandom_range(1, MAX_GAP);
  endfunction

  function automatic logic draw_sda(input int pct_low);
    return ($urandom_range(0, 99) < pct_low) ? 1'b0 : 1'b1;
  endfunction

  // Result side: per-item stalls, plus one long hold when asked for.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      @(negedge clk_i);
    end
  end

  // Called and returns at a falling edge; valid stays high for the next tick.
  task automatic send_tick(input logic [2:0] op, input logic [7:0] tx, input logic sda);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.op      <= op;
    tick_ch.tx_byte <= tx;
    tick_ch.sda_in  <= sda;
    do @(posedge clk_i); while (!tick_ch.ready);
    @(negedge clk_i);
  endtask

  // Issues one command and keeps the bus ticking until it reports done. The
  // two ticks right after the command are always taken while the engine is
  // busy, so a command placed there must be ignored.
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input int pct_low,
                         input bit try_busy);
    int         base;
    int         fill;
    logic [2:0] extra;
    base = dones_seen;
    cmds_issued++;
    send_tick(op, tx, draw_sda(pct_low));
    if (op >= i2cbe_pkg::OP_START && op <= i2cbe_pkg::OP_READ_NACK) begin
      fill = 0;
      while (dones_seen == base && fill < FILL_CAP) begin
        extra = i2cbe_pkg::OP_NONE;
        if (fill < 2 && try_busy) extra = 3'($urandom_range(0, 7));
        send_tick(extra, 8'($urandom_range(0, 255)), draw_sda(pct_low));
        fill++;
      end
    end
  endtask

  // Stops between commands once the tick budget is used up.
  task automatic run_transaction(input int pct_low);
    logic [2:0] ops[$];
    int         body;
    ops  = {i2cbe_pkg::OP_START, i2cbe_pkg::OP_WRITE};
    body = $urandom_range(1, 4);
    repeat (body) begin
      case ($urandom_range(0, 2))
        0:       ops.push_back(i2cbe_pkg::OP_WRITE);
        1:       ops.push_back(i2cbe_pkg::OP_READ_ACK);
        default: ops.push_back(i2cbe_pkg::OP_READ_NACK);
      endcase
    end
    ops.push_back(i2cbe_pkg::OP_STOP);
    foreach (ops[k]) begin
      if (ticks_sent >= ITEM_TARGET) break;
      if ($urandom_range(0, 9) == 0) ops[k] = 3'($urandom_range(0, 7));
      run_cmd(ops[k], 8'($urandom_range(0, 255)), pct_low, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (results_seen != ticks_sent) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_idx  <= idx;
    cfg_data <= data;
    cfg_we   <= 1'b1;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int          phase_no;
    int          pct;
    logic [15:0] dly;
    logic [15:0] tmo;
    rst_ni          = 1'b0;
    tick_ch.valid   = 1'b0;
    tick_ch.op      = i2cbe_pkg::OP_NONE;
    tick_ch.tx_byte = 8'd0;
    tick_ch.sda_in  = 1'b1;
    cfg_we          = 1'b0;
    cfg_idx         = i2cbe_pkg::REG_DELAY_TICKS;
    cfg_data        = 16'd0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed commands at the reset settings: idle and reserved ops, every
    // command, all-ones and all-zeros bytes, commands offered while busy.
    run_cmd(i2cbe_pkg::OP_NONE, 8'h00, 50, 1'b0);
    run_cmd(OP_RSVD6, 8'hFF, 50, 1'b0);
    run_cmd(OP_RSVD7, 8'h00, 50, 1'b0);
    run_cmd(i2cbe_pkg::OP_START, 8'h00, 50, 1'b1);
    run_cmd(i2cbe_pkg::OP_WRITE, 8'hFF, 100, 1'b1);
    run_cmd(i2cbe_pkg::OP_WRITE, 8'h00, 100, 1'b0);
    run_cmd(i2cbe_pkg::OP_WRITE, 8'hA5, 80, 1'b1);
    run_cmd(i2cbe_pkg::OP_READ_ACK, 8'h00, 0, 1'b0);
    run_cmd(i2cbe_pkg::OP_READ_NACK, 8'hFF, 100, 1'b1);
    run_cmd(i2cbe_pkg::OP_START, 8'h00, 50, 1'b0);
    run_cmd(i2cbe_pkg::OP_STOP, 8'h00, 50, 1'b1);

    // Zero registers act as one; a write with no acknowledge aborts.
    drain_results();
    write_reg(i2cbe_pkg::REG_DELAY_TICKS, 16'd0);
    write_reg(i2cbe_pkg::REG_ACK_TIMEOUT, 16'd0);
    run_cmd(i2cbe_pkg::OP_WRITE, 8'h3C, 0, 1'b1);
    drain_results();
    write_reg(i2cbe_pkg::REG_ACK_TIMEOUT, 16'd2);
    run_cmd(i2cbe_pkg::OP_WRITE, 8'hC3, 0, 1'b0);
    run_cmd(i2cbe_pkg::OP_READ_NACK, 8'h00, 50, 1'b0);

    for (phase_no = 0; ticks_sent < ITEM_TARGET; phase_no++) begin
      drain_results();
      case (phase_no)
        0: begin
          dly = 16'd1;
          tmo = 16'd1;
          pct = 50;
        end
        1: begin
          dly = 16'd1;
          tmo = 16'hFFFF;
          pct = 40;
        end
        2: begin
          dly = 16'd0;
          tmo = 16'd3;
          pct = 10;
        end
        3: begin
          dly = 16'd4;
          tmo = 16'd0;
          pct = 60;
        end
        default: begin
          dly = 16'($urandom_range(0, 5));
          tmo = 16'($urandom_range(0, 8));
          case ($urandom_range(0, 3))
            0:       pct = 5;
            1:       pct = 30;
            2:       pct = 60;
            default: pct = 95;
          endcase
        end
      endcase
      write_reg(i2cbe_pkg::REG_DELAY_TICKS, dly);
      write_reg(i2cbe_pkg::REG_ACK_TIMEOUT, tmo);
      gaps_on = (phase_no % 3 != 2);
      // Hold the result side off long enough for the input to stall.
      if (phase_no == 0) hold_req = HOLD_CYCLES;
      run_transaction(pct);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("tb_top: %0d bus ticks, %0d commands issued, %0d finished, %0d ack timeouts",
             ticks_sent, cmds_issued, dones_seen, aborts_seen);
    $display("tb_top: all commands, busy and reserved ops, zero and small register values,");
    $display("tb_top: acknowledge timeouts and stalls on both channels");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      if (pending != 0) $display("tb_top: %0d expected results never arrived", pending);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
